// ===== rtl/val_pkg.sv =====
// ============================================================================
// val_pkg
// Shared types, constants and the control program of the vector
// acceleration limiter.
// ============================================================================
`default_nettype none

package val_pkg;

    localparam int SPEED_BITS_DEF = 16;
    localparam int CFG_BITS       = 16;
    localparam logic [CFG_BITS-1:0] MAX_STEP_RST = 16'd819;

    localparam int PC_BITS = 5;
    typedef logic [PC_BITS-1:0] pc_t;

    localparam pc_t ST_LOAD    = 5'd0;
    localparam pc_t ST_DIFF    = 5'd1;
    localparam pc_t ST_MAG     = 5'd2;
    localparam pc_t ST_SQX     = 5'd3;
    localparam pc_t ST_SQY     = 5'd4;
    localparam pc_t ST_ADD     = 5'd5;
    localparam pc_t ST_SQRT    = 5'd6;
    localparam pc_t ST_CMP     = 5'd7;
    localparam pc_t ST_MULX    = 5'd8;
    localparam pc_t ST_DINITX  = 5'd9;
    localparam pc_t ST_DIVX    = 5'd10;
    localparam pc_t ST_APPLYX  = 5'd11;
    localparam pc_t ST_MULY    = 5'd12;
    localparam pc_t ST_DINITY  = 5'd13;
    localparam pc_t ST_DIVY    = 5'd14;
    localparam pc_t ST_APPLYY  = 5'd15;
    localparam pc_t ST_EMIT    = 5'd16;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_DIFF,
        OP_MAG,
        OP_SQX,
        OP_SQY,
        OP_ADD,
        OP_SQ_STEP,
        OP_CMP,
        OP_MUL,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_APPLY,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        C_NONE,
        C_ALWAYS,
        C_NO_IN,
        C_OUT_BUSY,
        C_CNT_NZ,
        C_NOT_LIM
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t wait_c;
        cond_t jmp_c;
        pc_t   target;
        logic  sel_y;
    } ctrl_t;

    typedef struct packed {
        logic cnt_nz;
        logic not_lim;
    } dp_stat_t;

    function automatic ctrl_t mk(op_t op, cond_t w, cond_t j, pc_t t, logic s);
        ctrl_t c;
        c.op     = op;
        c.wait_c = w;
        c.jmp_c  = j;
        c.target = t;
        c.sel_y  = s;
        return c;
    endfunction

    function automatic ctrl_t ucode(pc_t pc);
        ctrl_t c;
        case (pc)
            ST_LOAD:   c = mk(OP_LOAD,      C_NO_IN,    C_NONE,    ST_LOAD,   1'b0);
            ST_DIFF:   c = mk(OP_DIFF,      C_NONE,     C_NONE,    ST_LOAD,   1'b0);
            ST_MAG:    c = mk(OP_MAG,       C_NONE,     C_NONE,    ST_LOAD,   1'b0);
            ST_SQX:    c = mk(OP_SQX,       C_NONE,     C_NONE,    ST_LOAD,   1'b0);
            ST_SQY:    c = mk(OP_SQY,       C_NONE,     C_NONE,    ST_LOAD,   1'b0);
            ST_ADD:    c = mk(OP_ADD,       C_NONE,     C_NONE,    ST_LOAD,   1'b0);
            ST_SQRT:   c = mk(OP_SQ_STEP,   C_NONE,     C_CNT_NZ,  ST_SQRT,   1'b0);
            ST_CMP:    c = mk(OP_CMP,       C_NONE,     C_NOT_LIM, ST_EMIT,   1'b0);
            ST_MULX:   c = mk(OP_MUL,       C_NONE,     C_NONE,    ST_LOAD,   1'b0);
            ST_DINITX: c = mk(OP_DIV_INIT,  C_NONE,     C_NONE,    ST_LOAD,   1'b0);
            ST_DIVX:   c = mk(OP_DIV_STEP,  C_NONE,     C_CNT_NZ,  ST_DIVX,   1'b0);
            ST_APPLYX: c = mk(OP_APPLY,     C_NONE,     C_NONE,    ST_LOAD,   1'b0);
            ST_MULY:   c = mk(OP_MUL,       C_NONE,     C_NONE,    ST_LOAD,   1'b1);
            ST_DINITY: c = mk(OP_DIV_INIT,  C_NONE,     C_NONE,    ST_LOAD,   1'b1);
            ST_DIVY:   c = mk(OP_DIV_STEP,  C_NONE,     C_CNT_NZ,  ST_DIVY,   1'b1);
            ST_APPLYY: c = mk(OP_APPLY,     C_NONE,     C_NONE,    ST_LOAD,   1'b1);
            ST_EMIT:   c = mk(OP_EMIT,      C_OUT_BUSY, C_ALWAYS,  ST_LOAD,   1'b0);
            default:   c = mk(OP_NOP,       C_NONE,     C_ALWAYS,  ST_LOAD,   1'b0);
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/val_dp.sv =====
// ============================================================================
// val_dp
// Datapath of the limiter: difference, shared multiplier, bit-serial
// square root and divider, saturation, previous-output state.
// ============================================================================
`default_nettype none

module val_dp #(
    parameter int SPEED_BITS = val_pkg::SPEED_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire val_pkg::ctrl_t                    ctrl,
    input  wire logic                              en,
    input  wire logic signed [SPEED_BITS-1:0]      cmd_x,
    input  wire logic signed [SPEED_BITS-1:0]      cmd_y,
    input  wire logic                              cfg_we,
    input  wire logic [val_pkg::CFG_BITS-1:0]      cfg_wdata,
    output val_pkg::dp_stat_t                      stat,
    output logic signed [SPEED_BITS-1:0]           res_x,
    output logic signed [SPEED_BITS-1:0]           res_y,
    output logic                                   lim
);

    localparam int SB = SPEED_BITS;
    localparam int QW = SB + 1;
    localparam int OW = (QW > val_pkg::CFG_BITS) ? QW : val_pkg::CFG_BITS;
    localparam int RW = 2 * QW;
    localparam int PW = 2 * OW;
    localparam int CW = $clog2(QW);

    localparam logic signed [SB-1:0] SAT_HI = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] SAT_LO = {1'b1, {(SB-1){1'b0}}};

    logic signed [SB-1:0]  cx_reg, cx_next, cy_reg, cy_next;
    logic signed [SB-1:0]  prev_x_reg, prev_x_next, prev_y_reg, prev_y_next;
    logic signed [SB:0]    dx_reg, dx_next, dy_reg, dy_next;
    logic [QW-1:0]         mx_reg, mx_next, my_reg, my_next;
    logic                  nx_reg, nx_next, ny_reg, ny_next;
    logic [PW-1:0]         prod_reg, prod_next;
    logic [RW-1:0]         acc_reg, acc_next;
    logic [RW-1:0]         sh_reg, sh_next;
    logic [QW+1:0]         rem_reg, rem_next;
    logic [QW-1:0]         root_reg, root_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic signed [SB-1:0]  res_x_reg, res_x_next, res_y_reg, res_y_next;
    logic                  lim_reg, lim_next;
    logic [val_pkg::CFG_BITS-1:0] max_step_reg;

    logic [OW-1:0]         mul_a, mul_b;
    logic [PW-1:0]         mul_p;
    logic [QW-1:0]         msel;
    logic                  nsel;
    logic signed [SB-1:0]  psel;
    logic [QW+3:0]         sq_t, sq_trial, sq_diff;
    logic                  sq_ge;
    logic [QW+1:0]         dv_t, dv_d, dv_diff;
    logic                  dv_ge;
    logic [PW-1:0]         prod_hi;
    logic signed [SB+1:0]  ap_q, ap_sum;
    logic signed [SB-1:0]  ap_sat;
    logic                  not_lim;

    assign msel = ctrl.sel_y ? my_reg : mx_reg;
    assign nsel = ctrl.sel_y ? ny_reg : nx_reg;
    assign psel = ctrl.sel_y ? prev_y_reg : prev_x_reg;

    always_comb
    begin
        case (ctrl.op)
            val_pkg::OP_SQX:
            begin
                mul_a = OW'(mx_reg);
                mul_b = OW'(mx_reg);
            end
            val_pkg::OP_SQY:
            begin
                mul_a = OW'(my_reg);
                mul_b = OW'(my_reg);
            end
            default:
            begin
                mul_a = OW'(msel);
                mul_b = OW'(max_step_reg);
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // square root: two radicand bits per step
    assign sq_t     = {rem_reg, sh_reg[RW-1 -: 2]};
    assign sq_trial = {2'b00, root_reg, 2'b01};
    assign sq_ge    = (sq_t >= sq_trial);
    assign sq_diff  = sq_t - sq_trial;

    // restoring division by the length, one quotient bit per step;
    // the quotient is below |d| so SB bits hold it
    assign dv_t    = {rem_reg[QW:0], sh_reg[SB-1]};
    assign dv_d    = {2'b00, root_reg};
    assign dv_ge   = (dv_t >= dv_d);
    assign dv_diff = dv_t - dv_d;

    assign prod_hi = prod_reg >> SB;

    assign ap_q   = nsel ? -$signed({2'b00, sh_reg[SB-1:0]}) : $signed({2'b00, sh_reg[SB-1:0]});
    assign ap_sum = {{2{psel[SB-1]}}, psel} + ap_q;

    always_comb
    begin
        if ((ap_sum[SB+1] == ap_sum[SB]) && (ap_sum[SB] == ap_sum[SB-1]))
        begin
            ap_sat = ap_sum[SB-1:0];
        end
        else if (ap_sum[SB+1])
        begin
            ap_sat = SAT_LO;
        end
        else
        begin
            ap_sat = SAT_HI;
        end
    end

    assign not_lim = !(OW'(root_reg) > OW'(max_step_reg));

    always_comb
    begin
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        prev_x_next = prev_x_reg;
        prev_y_next = prev_y_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        mx_next     = mx_reg;
        my_next     = my_reg;
        nx_next     = nx_reg;
        ny_next     = ny_reg;
        prod_next   = prod_reg;
        acc_next    = acc_reg;
        sh_next     = sh_reg;
        rem_next    = rem_reg;
        root_next   = root_reg;
        cnt_next    = cnt_reg;
        res_x_next  = res_x_reg;
        res_y_next  = res_y_reg;
        lim_next    = lim_reg;
        if (en)
        begin
            case (ctrl.op)
                val_pkg::OP_LOAD:
                begin
                    cx_next = cmd_x;
                    cy_next = cmd_y;
                end
                val_pkg::OP_DIFF:
                begin
                    dx_next = {cx_reg[SB-1], cx_reg} - {prev_x_reg[SB-1], prev_x_reg};
                    dy_next = {cy_reg[SB-1], cy_reg} - {prev_y_reg[SB-1], prev_y_reg};
                end
                val_pkg::OP_MAG:
                begin
                    nx_next = dx_reg[SB];
                    ny_next = dy_reg[SB];
                    mx_next = dx_reg[SB] ? QW'(-dx_reg) : QW'(dx_reg);
                    my_next = dy_reg[SB] ? QW'(-dy_reg) : QW'(dy_reg);
                end
                val_pkg::OP_SQX:
                begin
                    prod_next = mul_p;
                end
                val_pkg::OP_SQY:
                begin
                    acc_next  = prod_reg[RW-1:0];
                    prod_next = mul_p;
                end
                val_pkg::OP_ADD:
                begin
                    sh_next   = acc_reg + prod_reg[RW-1:0];
                    rem_next  = '0;
                    root_next = '0;
                    cnt_next  = CW'(SB);
                end
                val_pkg::OP_SQ_STEP:
                begin
                    rem_next  = sq_ge ? sq_diff[QW+1:0] : sq_t[QW+1:0];
                    root_next = {root_reg[QW-2:0], sq_ge};
                    sh_next   = {sh_reg[RW-3:0], 2'b00};
                    cnt_next  = cnt_reg - 1'b1;
                end
                val_pkg::OP_CMP:
                begin
                    lim_next   = !not_lim;
                    res_x_next = cx_reg;
                    res_y_next = cy_reg;
                end
                val_pkg::OP_MUL:
                begin
                    prod_next = mul_p;
                end
                val_pkg::OP_DIV_INIT:
                begin
                    rem_next = prod_hi[QW+1:0];
                    sh_next  = RW'(prod_reg[SB-1:0]);
                    cnt_next = CW'(SB-1);
                end
                val_pkg::OP_DIV_STEP:
                begin
                    rem_next = dv_ge ? dv_diff : dv_t;
                    sh_next  = RW'({sh_reg[SB-2:0], dv_ge});
                    cnt_next = cnt_reg - 1'b1;
                end
                val_pkg::OP_APPLY:
                begin
                    if (ctrl.sel_y)
                    begin
                        res_y_next = ap_sat;
                    end
                    else
                    begin
                        res_x_next = ap_sat;
                    end
                end
                val_pkg::OP_EMIT:
                begin
                    prev_x_next = res_x_reg;
                    prev_y_next = res_y_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg   <= '0;
            prev_y_reg   <= '0;
            cnt_reg      <= '0;
            lim_reg      <= 1'b0;
            max_step_reg <= val_pkg::MAX_STEP_RST;
        end
        else
        begin
            prev_x_reg <= prev_x_next;
            prev_y_reg <= prev_y_next;
            cnt_reg    <= cnt_next;
            lim_reg    <= lim_next;
            if (cfg_we)
            begin
                max_step_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        mx_reg    <= mx_next;
        my_reg    <= my_next;
        nx_reg    <= nx_next;
        ny_reg    <= ny_next;
        prod_reg  <= prod_next;
        acc_reg   <= acc_next;
        sh_reg    <= sh_next;
        rem_reg   <= rem_next;
        root_reg  <= root_next;
        res_x_reg <= res_x_next;
        res_y_reg <= res_y_next;
    end

    assign stat  = {(cnt_reg != '0), not_lim};
    assign res_x = res_x_reg;
    assign res_y = res_y_reg;
    assign lim   = lim_reg;

endmodule

`default_nettype wire

// ===== rtl/vector_acceleration_limiter_top.sv =====
// ============================================================================
// vector_acceleration_limiter_top
// Limits the change of a planar speed pair per tick to a configured
// vector length, scaling the change along its own direction.
// ============================================================================
//
//  channel   | direction | tdata (low bit up)      | tuser
//  ----------+-----------+-------------------------+-------------
//  s_axis    | in        | cmd_x, cmd_y, zero pad  | -
//  m_axis    | out       | out_x, out_y, zero pad  | was_limited
//  cfg       | in        | max_step (write only)   | -
//
//  A microcoded sequencer runs one item at a time; a limited item also
//  scales both components, each by a multiply and a bit-serial divide.
//  The square root and the divider are bit-serial loops.
//  Reset clears the sequencer and the previous pair and sets max_step to 819.
//  The result register holds while m_axis stalls; the next item is
//  accepted meanwhile and waits only at its own emit step.
//
`default_nettype none

module vector_acceleration_limiter_top #(
    parameter int SPEED_BITS = val_pkg::SPEED_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // cmd_x, cmd_y, zero pad
    input  wire logic [((2*SPEED_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // out_x, out_y, zero pad
    output logic [((2*SPEED_BITS+7)/8)*8-1:0]  m_axis_tdata,
    // was_limited
    output logic                               m_axis_tuser,
    input  wire logic                          cfg_we,
    input  wire logic [val_pkg::CFG_BITS-1:0]  cfg_wdata
);

    localparam int SB  = SPEED_BITS;
    localparam int TW  = ((2*SB+7)/8)*8;

    val_pkg::pc_t      pc_reg, pc_next;
    val_pkg::ctrl_t    ctrl;
    val_pkg::dp_stat_t stat;
    logic              wait_now, jmp_now, en;
    logic              out_busy;

    logic                  out_valid_reg, out_valid_next;
    logic signed [SB-1:0]  out_x_reg, out_y_reg;
    logic                  out_lim_reg;
    logic signed [SB-1:0]  res_x, res_y;
    logic                  lim;

    function automatic logic cond_eval(val_pkg::cond_t c, logic in_v, logic busy,
                                       val_pkg::dp_stat_t st);
        logic r;
        case (c)
            val_pkg::C_ALWAYS:   r = 1'b1;
            val_pkg::C_NO_IN:    r = !in_v;
            val_pkg::C_OUT_BUSY: r = busy;
            val_pkg::C_CNT_NZ:   r = st.cnt_nz;
            val_pkg::C_NOT_LIM:  r = st.not_lim;
            default:             r = 1'b0;
        endcase
        return r;
    endfunction

    assign ctrl     = val_pkg::ucode(pc_reg);
    assign out_busy = out_valid_reg && !m_axis_tready;
    assign wait_now = cond_eval(ctrl.wait_c, s_axis_tvalid, out_busy, stat);
    assign jmp_now  = cond_eval(ctrl.jmp_c, s_axis_tvalid, out_busy, stat);
    assign en       = !wait_now;

    always_comb
    begin
        if (wait_now)
        begin
            pc_next = pc_reg;
        end
        else if (jmp_now)
        begin
            pc_next = ctrl.target;
        end
        else
        begin
            pc_next = pc_reg + 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !m_axis_tready;
        if (en && (ctrl.op == val_pkg::OP_EMIT))
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= val_pkg::ST_LOAD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && (ctrl.op == val_pkg::OP_EMIT))
        begin
            out_x_reg   <= res_x;
            out_y_reg   <= res_y;
            out_lim_reg <= lim;
        end
    end

    val_dp #(
        .SPEED_BITS (SPEED_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .en        (en),
        .cmd_x     (s_axis_tdata[SB-1:0]),
        .cmd_y     (s_axis_tdata[2*SB-1:SB]),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .stat      (stat),
        .res_x     (res_x),
        .res_y     (res_y),
        .lim       (lim)
    );

    assign s_axis_tready = (ctrl.op == val_pkg::OP_LOAD);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = TW'({out_y_reg, out_x_reg});
    assign m_axis_tuser  = out_lim_reg;

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// ============================================================================
// tb
// Self-checking bench for vector_acceleration_limiter_top. It drives speed
// commands over the input stream and writes max_step only while the block is
// idle. Every output transfer is checked against a bit-accurate model of the
// slew limiter that runs inside the bench. Both stream sides stall in random
// bursts.
// ============================================================================
`default_nettype none

module tb;

    localparam int SPD_W       = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 80;

    typedef struct {
        logic signed [SPD_W-1:0] x;
        logic signed [SPD_W-1:0] y;
        logic                    lim;
    } speed_pair_t;

    class slew_tracker;
        logic [val_pkg::CFG_BITS-1:0] max_step;
        logic signed [SPD_W-1:0]      prev_x;
        logic signed [SPD_W-1:0]      prev_y;
        speed_pair_t                  limited_q[$];
        int                           mismatches;
        int                           n_limited;
        int                           n_passed;

        function new();
            max_step   = val_pkg::MAX_STEP_RST;
            prev_x     = '0;
            prev_y     = '0;
            mismatches = 0;
            n_limited  = 0;
            n_passed   = 0;
        endfunction

        static function longint clip(longint v);
            if (v > 32767)
                return 32767;
            if (v < -32768)
                return -32768;
            return v;
        endfunction

        // floor(sqrt(n)); n < 2^34 so the root fits in 17 bits
        static function longint floor_root(longint n);
            longint r;
            longint c;
            r = 0;
            for (int b = 17; b >= 0; b--)
            begin
                c = r | (longint'(1) << b);
                if (c * c <= n)
                    r = c;
            end
            return r;
        endfunction

        function longint shrink(longint d, longint len);
            longint q;
            q = ((d < 0 ? -d : d) * longint'(max_step)) / len;
            return d < 0 ? -q : q;
        endfunction

        function void accept_cmd(logic signed [SPD_W-1:0] cx, logic signed [SPD_W-1:0] cy);
            longint      dx;
            longint      dy;
            longint      len;
            longint      ox;
            longint      oy;
            speed_pair_t e;
            dx    = longint'(cx) - longint'(prev_x);
            dy    = longint'(cy) - longint'(prev_y);
            len   = floor_root(dx * dx + dy * dy);
            ox    = cx;
            oy    = cy;
            e.lim = 1'b0;
            if (len > longint'(max_step))
            begin
                ox    = clip(longint'(prev_x) + shrink(dx, len));
                oy    = clip(longint'(prev_y) + shrink(dy, len));
                e.lim = 1'b1;
            end
            e.x    = ox[SPD_W-1:0];
            e.y    = oy[SPD_W-1:0];
            prev_x = e.x;
            prev_y = e.y;
            limited_q.push_back(e);
        endfunction

        function void check_output(logic signed [SPD_W-1:0] ax, logic signed [SPD_W-1:0] ay,
                                   logic alim);
            speed_pair_t e;
            if (limited_q.size() == 0)
            begin
                $error("unexpected output transfer: out_x %0d out_y %0d", ax, ay);
                mismatches++;
                return;
            end
            e = limited_q.pop_front();
            if (alim)
                n_limited++;
            else
                n_passed++;
            if (ax !== e.x)
            begin
                $error("out_x: expected %0d, actual %0d", e.x, ax);
                mismatches++;
            end
            if (ay !== e.y)
            begin
                $error("out_y: expected %0d, actual %0d", e.y, ay);
                mismatches++;
            end
            if (alim !== e.lim)
            begin
                $error("was_limited: expected %0d, actual %0d", e.lim, alim);
                mismatches++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // cmd_x, cmd_y
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // out_x, out_y
    logic        m_axis_tuser;   // was_limited
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    slew_tracker tracker = new();
    bit          calm = 1'b0;
    int          cycles = 0;
    int          n_cmds = 0;
    int          n_settings = 1;

    vector_acceleration_limiter_top #(
        .SPEED_BITS (SPD_W)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            tracker.accept_cmd(s_axis_tdata[15:0], s_axis_tdata[31:16]);
            n_cmds++;
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_output(m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tuser);
    end

    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 7) == 0)
            begin
                stall = $urandom_range(1, 9);
                m_axis_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready = 1'b1;
        end
    end

    // returns at the falling edge after the transfer, tvalid still high
    task automatic send_cmd(input logic signed [15:0] cx, input logic signed [15:0] cy);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 9);
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {cy, cx};
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (tracker.limited_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_max_step(input logic [15:0] v);
        cfg_we    = 1'b1;
        cfg_wdata = v;
        @(negedge clk);
        cfg_we = 1'b0;
        tracker.max_step = v;
        n_settings++;
    endtask

    initial
    begin
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic [15:0]        step;
        longint             span;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        rst_n         = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset max_step: zero change, length at the limit, one above, extremes
        send_cmd(16'sd0, 16'sd0);
        send_cmd(16'sd819, 16'sd0);
        send_cmd(16'sd819, 16'sd820);
        send_cmd(16'sd32767, 16'sd32767);
        send_cmd(-16'sd32768, -16'sd32768);
        send_cmd(16'sd32767, -16'sd32768);
        send_cmd(-16'sd32768, 16'sd32767);
        send_cmd(16'sd0, 16'sd0);
        drain();

        // zero max_step freezes the output on any nonzero change
        write_max_step(16'd0);
        send_cmd(tracker.prev_x, tracker.prev_y);
        send_cmd(16'sd32767, -16'sd32768);
        send_cmd(-16'sd1, 16'sd1);
        send_cmd(tracker.prev_x, tracker.prev_y);
        drain();

        write_max_step(16'hFFFF);
        send_cmd(-16'sd32768, -16'sd32768);
        send_cmd(16'sd32767, 16'sd32767);
        send_cmd(16'sd32767, 16'sd32767);
        send_cmd(16'sd0, -16'sd32768);
        send_cmd(-16'sd32768, 16'sd0);
        send_cmd(16'sd32767, -16'sd32768);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: step = 16'($urandom_range(1, 4000));
                1: step = 16'd0;
                2: step = 16'($urandom);
                3: step = 16'hFFFF;
                4: step = 16'($urandom_range(100, 2000));
                default: step = val_pkg::MAX_STEP_RST;
            endcase
            write_max_step(step);
            calm = (ph == 5);
            repeat (100)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3:
                    begin
                        cx = 16'($urandom);
                        cy = 16'($urandom);
                    end
                    4, 5, 6, 7:
                    begin
                        span = (tracker.max_step == 0) ? 4 : 2 * longint'(tracker.max_step);
                        cx = 16'(slew_tracker::clip(longint'(tracker.prev_x)
                             + longint'($urandom_range(0, 32'(2 * span))) - span));
                        cy = 16'(slew_tracker::clip(longint'(tracker.prev_y)
                             + longint'($urandom_range(0, 32'(2 * span))) - span));
                    end
                    8:
                    begin
                        cx = tracker.prev_x;
                        cy = tracker.prev_y;
                    end
                    default:
                    begin
                        cx = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                        cy = $urandom_range(0, 2) == 0 ? 16'sh0000 :
                             ($urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000);
                    end
                endcase
                send_cmd(cx, cy);
            end
            drain();
        end

        $display("Sent %0d speed commands across %0d max_step settings.", n_cmds, n_settings);
        $display("Outputs: %0d limited, %0d passed through.", tracker.n_limited,
                 tracker.n_passed);
        if (tracker.mismatches == 0 && tracker.limited_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire
